### rtl/bhfd_pkg.sv
// Shared types and constants of the bit header frame deframer.
package bhfd_pkg;

   localparam int MAX_PAYLOAD_BYTES = 65536;
   localparam int PCNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam int MCAP_W = 9;
   localparam int PCAP_W = 17;
   localparam int CMP_W = (PCNT_W > PCAP_W) ? PCNT_W : PCAP_W;
   localparam int QDEPTH = 4;
   localparam int QAW = $clog2(QDEPTH);

   localparam logic [MCAP_W-1:0] MCAP_RESET = MCAP_W'(256);
   localparam logic [PCAP_W-1:0] PCAP_RESET = PCAP_W'(65536);

   typedef enum logic {
      CSR_MDCAP = 1'b0,
      CSR_PCAP  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_TRUNC  = 3'd1,
      ST_BADVER = 3'd2,
      ST_COMP   = 3'd3,
      ST_CAP    = 3'd4
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // One queue entry: the results caused by one accepted byte.
   typedef struct packed {
      logic       has_data;
      logic       region;
      logic [7:0] data;
      logic [4:0] mtype;
      logic [7:0] mdlen;
      logic [15:0] pcount;
      logic       has_status;
      status_type status;
   } entry_type;

endpackage

### rtl/bit_header_frame_deframer.sv
// Top level of the bit header frame deframer.
// The deframer takes one frame byte per clock cycle, pipelined: a byte is
// accepted at every edge where push is high and full is low, and its header
// bits, realigned data bits and end-of-frame check are all worked out in the
// cycle it is accepted, by eight-bit parallel shift logic in the front end.
// The results of a byte enter a four-entry queue and appear on the result side
// from the next cycle. The back end hands out one result per cycle while the
// consumer pops, so a byte that yields a data byte and a status gives two
// results, data first. Full rises once four entries wait: when the consumer
// stalls, or when bytes that each yield two results arrive faster than the
// back end hands them out. Capacity registers are written through the csr_
// port, by the user only while the block is idle; the block does not check it.
module bit_header_frame_deframer import bhfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_end_of_frame,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_item_kind,
   output logic              rsp_region,
   output logic [7:0]        rsp_data_value,
   output logic [4:0]        rsp_message_type,
   output logic [7:0]        rsp_metadata_length,
   output logic [15:0]       rsp_payload_count,
   output logic [2:0]        rsp_status,
   output logic              rsp_last_of_run,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [PCAP_W-1:0] csr_wdata
);

   entry_type q_entry, q_head;
   logic      q_push, q_full, q_pop, q_empty;

   assign req_full = q_full;

   bhfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_frame_byte   (req_frame_byte),
      .req_end_of_frame (req_end_of_frame),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   bhfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   bhfd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (q_head),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_region          (rsp_region),
      .rsp_data_value      (rsp_data_value),
      .rsp_message_type    (rsp_message_type),
      .rsp_metadata_length (rsp_metadata_length),
      .rsp_payload_count   (rsp_payload_count),
      .rsp_status          (rsp_status),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

### rtl/bhfd_front.sv
// Front end: header parse and byte realignment, one byte per cycle unless q_full.
module bhfd_front import bhfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_end_of_frame,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [PCAP_W-1:0] csr_wdata,
   input  logic              q_full,
   output logic              q_push,
   output entry_type         q_entry
);

   typedef enum logic [2:0] {
      PH_PAD       = 3'd0,
      PH_VERSIONED = 3'd1,
      PH_VERSION   = 3'd2,
      PH_TYPE      = 3'd3,
      PH_COMP      = 3'd4,
      PH_MDLEN     = 3'd5,
      PH_META      = 3'd6,
      PH_PAYLOAD   = 3'd7
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [7:0]         carry;
      logic [2:0]         ccount;
      logic [7:0]         facc;
      logic [3:0]         fleft;
      logic [4:0]         mtype;
      logic [7:0]         mdlen;
      logic [7:0]         mleft;
      logic [PCNT_W-1:0]  pcnt;
      status_type         err;
      logic               comp;
   } fstate_type;

   fstate_type        st_ff, st_in;
   logic [MCAP_W-1:0] mcap_ff, mcap_in;
   logic [PCAP_W-1:0] pcap_ff, pcap_in;
   logic              accept;

   assign accept = req_push & ~q_full;

   always_comb begin
      fstate_type       s;
      fstate_type       clr;
      entry_type        e;
      logic             b;
      logic [CMP_W-1:0] cap;
      logic [CMP_W-1:0] cnt;

      s = st_ff;
      e = '0;
      clr = '0;
      clr.phase = PH_PAD;
      clr.err = ST_OK;

      // Walk the eight bits, most significant first; an error stops the walk.
      for (int i = 7; i >= 0; i--) begin
         b = req_frame_byte[i];
         if (s.err == ST_OK) begin
            case (s.phase)
               PH_PAD: begin
                  if (b) s.phase = PH_VERSIONED;
               end
               PH_VERSIONED: begin
                  s.facc = '0;
                  if (b) begin
                     s.phase = PH_VERSION;
                     s.fleft = 4'd8;
                  end else begin
                     s.phase = PH_TYPE;
                     s.fleft = 4'd5;
                  end
               end
               PH_COMP: begin
                  s.comp = b;
                  s.phase = PH_MDLEN;
                  s.facc = '0;
                  s.fleft = 4'd8;
               end
               PH_VERSION, PH_TYPE, PH_MDLEN: begin
                  s.facc = {s.facc[6:0], b};
                  if (s.fleft != '0) s.fleft = s.fleft - 4'd1;
                  if (s.fleft == '0) begin
                     case (s.phase)
                        PH_VERSION: begin
                           if (s.facc > 8'd1) begin
                              s.err = ST_BADVER;
                           end else begin
                              s.phase = PH_TYPE;
                              s.facc = '0;
                              s.fleft = 4'd5;
                           end
                        end
                        PH_TYPE: begin
                           s.mtype = s.facc[4:0];
                           s.phase = PH_COMP;
                        end
                        default: begin
                           s.mdlen = s.facc;
                           s.carry = '0;
                           s.ccount = '0;
                           if (s.comp) begin
                              s.err = ST_COMP;
                           end else if (({1'b0, s.facc} + 9'd1) > mcap_ff) begin
                              s.err = ST_CAP;
                           end else if (s.facc == '0) begin
                              s.phase = PH_PAYLOAD;
                           end else begin
                              s.mleft = s.facc;
                              s.phase = PH_META;
                           end
                        end
                     endcase
                  end
               end
               default: begin
                  s.carry = {s.carry[6:0], b};
                  if (s.ccount == 3'd7) begin
                     e.has_data = 1'b1;
                     e.data = s.carry;
                     s.carry = '0;
                     s.ccount = '0;
                     if (s.phase == PH_META) begin
                        e.region = 1'b0;
                        if (s.mleft != '0) s.mleft = s.mleft - 8'd1;
                        if (s.mleft == '0) s.phase = PH_PAYLOAD;
                     end else begin
                        e.region = 1'b1;
                        if (s.pcnt < PCNT_W'(MAX_PAYLOAD_BYTES)) s.pcnt = s.pcnt + 1'b1;
                     end
                  end else begin
                     s.ccount = s.ccount + 3'd1;
                  end
               end
            endcase
         end
      end

      // Effective payload capacity is the smaller of the register and the buffer.
      cap = (CMP_W'(pcap_ff) < CMP_W'(MAX_PAYLOAD_BYTES)) ?
            CMP_W'(pcap_ff) : CMP_W'(MAX_PAYLOAD_BYTES);
      cnt = CMP_W'(s.pcnt);

      e.mtype = s.mtype;
      e.mdlen = s.mdlen;
      e.pcount = (cnt > CMP_W'(16'hFFFF)) ? 16'hFFFF : cnt[15:0];
      e.has_status = req_end_of_frame;
      if (s.err != ST_OK) e.status = s.err;
      else if (s.phase != PH_PAYLOAD) e.status = ST_TRUNC;
      else if (cnt >= cap) e.status = ST_CAP;
      else e.status = ST_OK;

      q_entry = e;
      q_push = accept & (e.has_data | req_end_of_frame);

      st_in = st_ff;
      if (accept) st_in = req_end_of_frame ? clr : s;

      mcap_in = mcap_ff;
      pcap_in = pcap_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MDCAP: mcap_in = csr_wdata[MCAP_W-1:0];
            CSR_PCAP:  pcap_in = csr_wdata;
            default:   mcap_in = mcap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         mcap_ff <= MCAP_RESET;
         pcap_ff <= PCAP_RESET;
      end else begin
         st_ff <= st_in;
         mcap_ff <= mcap_in;
         pcap_ff <= pcap_in;
      end
   end

endmodule

### rtl/bhfd_queue.sv
// Short queue of result entries between the front and back ends.
module bhfd_queue import bhfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   entry_type        mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == (QAW+1)'(QDEPTH));
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push & ~do_pop) count_in = count_ff + 1'b1;
      else if (do_pop & ~do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/bhfd_back.sv
// Back end: unpacks each queue entry into a data transaction and/or a status transaction.
module bhfd_back import bhfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_item_kind,
   output logic       rsp_region,
   output logic [7:0] rsp_data_value,
   output logic [4:0] rsp_message_type,
   output logic [7:0] rsp_metadata_length,
   output logic [15:0] rsp_payload_count,
   output logic [2:0] rsp_status,
   output logic       rsp_last_of_run
);

   // Set once the data half of the head entry has gone out.
   logic sub_ff, sub_in;
   logic show_data;
   logic taken;

   assign show_data = head.has_data & ~sub_ff;
   assign taken = rsp_pop & ~q_empty;

   always_comb begin
      rsp_empty = q_empty;
      rsp_message_type = head.mtype;
      rsp_metadata_length = head.mdlen;
      rsp_payload_count = head.pcount;
      if (show_data) begin
         rsp_item_kind = KIND_DATA;
         rsp_region = head.region;
         rsp_data_value = head.data;
         rsp_status = ST_OK;
         rsp_last_of_run = ~head.has_status;
      end else begin
         rsp_item_kind = KIND_STATUS;
         rsp_region = 1'b0;
         rsp_data_value = '0;
         rsp_status = head.status;
         rsp_last_of_run = 1'b1;
      end

      // Hold the entry while its status half is still to go.
      q_pop = taken & ~(show_data & head.has_status);
      sub_in = sub_ff;
      if (taken) sub_in = show_data & head.has_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

### rtl/bhfd_checker.sv
// Port-level checks of the deframer and their bind to the top level.
module bhfd_checker import bhfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_item_kind,
   input logic        rsp_region,
   input logic [7:0]  rsp_data_value,
   input logic [2:0]  rsp_status,
   input logic        rsp_last_of_run
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not clear after reset");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item_kind == KIND_STATUS) |->
         (rsp_last_of_run && !rsp_region && rsp_data_value == 8'd0))
      else $error("status transaction with data fields set");

   a_data_status_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item_kind == KIND_DATA) |-> (rsp_status == ST_OK))
      else $error("data transaction with non-zero status");

   a_status_follows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_item_kind == KIND_DATA && !rsp_last_of_run) |=>
         (!rsp_empty && rsp_item_kind == KIND_STATUS))
      else $error("data transaction not followed by its status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status <= 3'd4))
      else $error("status code out of range");

endmodule

bind bit_header_frame_deframer bhfd_checker u_bhfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_item_kind   (rsp_item_kind),
   .rsp_region      (rsp_region),
   .rsp_data_value  (rsp_data_value),
   .rsp_status      (rsp_status),
   .rsp_last_of_run (rsp_last_of_run)
);
